### design/pic_pkg.sv
// ----------------------------------------------------------------------------
// Priority interrupt controller package
// Shared types, constants and the bus lane decoder for the two-level
// interrupt controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

  localparam int NUM_SOURCES = 16;
  localparam int SRC_W       = 16;
  localparam int ADDR_W      = 12;
  localparam int DATA_W      = 8;
  localparam int IDX_W       = 4;

  localparam int PRIO_MODE_BIT   = 7;
  localparam int HIGH_ENABLE_BIT = 7;
  localparam int LOW_ENABLE_BIT  = 6;

  localparam logic [SRC_W-1:0] SRC_MASK =
    (NUM_SOURCES >= SRC_W) ? {SRC_W{1'b1}} : SRC_W'((32'd1 << NUM_SOURCES) - 32'd1);
  localparam logic [IDX_W:0] SRC_LIMIT = (IDX_W + 1)'(NUM_SOURCES);

  localparam logic [DATA_W-1:0] INTCON_MASK =
    DATA_W'((32'd1 << HIGH_ENABLE_BIT) | (32'd1 << LOW_ENABLE_BIT));
  localparam logic [DATA_W-1:0] RCON_MASK   = DATA_W'(32'd1 << PRIO_MODE_BIT);

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_FLAG  = 2'd3;

  localparam int CFG_ADDR_W = 5;
  localparam logic [2:0] REG_INTCON   = 3'd0;
  localparam logic [2:0] REG_RCON     = 3'd1;
  localparam logic [2:0] REG_ENABLE   = 3'd2;
  localparam logic [2:0] REG_PRIORITY = 3'd3;
  localparam logic [2:0] REG_FLAG     = 3'd4;
  localparam logic [2:0] REG_PERIPH   = 3'd5;
  localparam logic [2:0] REG_RDONLY   = 3'd6;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic [IDX_W-1:0]  source_index;
    logic              flag_value;
  } pic_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] claimed_mask;
    logic              wake;
    logic              vector_taken;
    logic              vector_high;
  } pic_result_t;

  typedef struct packed {
    logic             prio_mode;
    logic             enable_high;
    logic             enable_low;
    logic [SRC_W-1:0] enabled;
    logic [SRC_W-1:0] high;
    logic [SRC_W-1:0] flagged;
  } pic_state_t;

  typedef struct packed {
    logic wake;
    logic vector_taken;
    logic vector_high;
    logic clear_high;
    logic clear_low;
  } pic_tick_t;

  typedef struct packed {
    logic              upper;
    logic [DATA_W-1:0] mask;
  } pic_lane_t;

  // Which byte of a two-byte source vector mapped at base answers at addr.
  function automatic pic_lane_t pic_lane(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] addr);
    pic_lane_t lane;
    lane.upper = 1'b0;
    lane.mask  = '0;
    if (base != '0) begin
      if (addr == base) begin
        lane.mask = SRC_MASK[7:0];
      end else if ({1'b0, addr} == ({1'b0, base} + (ADDR_W + 1)'(1))) begin
        lane.upper = 1'b1;
        lane.mask  = SRC_MASK[15:8];
      end
    end
    return lane;
  endfunction

endpackage

`default_nettype wire

### design/pic_item_if.sv
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel that carries one tick, bus access or flag update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pic_item_if import pic_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;
  logic [IDX_W-1:0]  source_index;
  logic              flag_value;

  modport source (output valid, operation, address, write_data, source_index, flag_value,
                  input ready);
  modport sink (input valid, operation, address, write_data, source_index, flag_value,
                output ready);
endinterface

`default_nettype wire

### design/pic_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the result of one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pic_result_if import pic_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [DATA_W-1:0] claimed_mask;
  logic              wake;
  logic              vector_taken;
  logic              vector_high;

  modport source (output valid, read_data, claimed_mask, wake, vector_taken, vector_high,
                  input ready);
  modport sink (input valid, read_data, claimed_mask, wake, vector_taken, vector_high,
                output ready);
endinterface

`default_nettype wire

### design/pic_arbiter.sv
// ----------------------------------------------------------------------------
// Interrupt arbiter
// Picks the first flagged, enabled source of the highest pending level and
// decides wake, vector and which global enable to clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pic_arbiter import pic_pkg::*; (
  input  pic_state_t       state,
  input  logic [SRC_W-1:0] peripheral,
  output pic_tick_t        tick
);

  logic [SRC_W-1:0] pending;
  logic [SRC_W-1:0] pend_high;
  logic [SRC_W-1:0] pend_low;
  logic [SRC_W-1:0] pick;
  logic [SRC_W-1:0] first;
  logic             req_high;
  logic             req_low;
  logic             periph;
  logic             fire_high;
  logic             fire_low;

  assign pending   = state.flagged & state.enabled & SRC_MASK;
  assign pend_high = pending & state.high;
  assign pend_low  = pending & ~state.high;
  assign req_high  = |pend_high;
  assign pick      = req_high ? pend_high : pend_low;
  // The lowest set bit of pick is the chosen source.
  assign first     = pick & (~pick + SRC_W'(1));
  assign periph    = |(first & peripheral);
  assign req_low   = state.prio_mode ? (!req_high && |pend_low) : (|pending);

  assign fire_high = state.prio_mode && state.enable_high && req_high;
  assign fire_low  = !fire_high && req_low && state.enable_high &&
                     (state.prio_mode ? state.enable_low : (!periph || state.enable_low));

  always_comb begin
    tick.wake         = req_high || req_low;
    tick.vector_taken = fire_high || fire_low;
    tick.vector_high  = fire_high;
    tick.clear_high   = fire_high || (fire_low && !state.prio_mode);
    tick.clear_low    = fire_low && state.prio_mode;
  end

endmodule

`default_nettype wire

### design/priority_interrupt_controller_unit.sv
// ----------------------------------------------------------------------------
// Priority interrupt controller unit
// Two-level interrupt controller behind byte-wide bus registers, with an
// APB-style port for its address map and source attributes.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake          Carries
//   item     in         valid/ready        tick, bus read/write, flag update
//   result   out        valid/ready        read data, claim mask, wake, vector
//   apb      in         psel/penable       address map and source attributes
//
// One transaction is accepted every cycle unless the result stalls; each result
// passes the input register and then the result register before it is offered.
// The source and enable state is read and updated by the single compute stage.
// A stalled result holds; the input register still takes one more transaction if it is empty.
// Reset clears all state, configuration and the valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module priority_interrupt_controller_unit import pic_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  pic_item_if.sink              item,
  pic_result_if.source          result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [ADDR_W-1:0] intcon_address;
  logic [ADDR_W-1:0] rcon_address;
  logic [ADDR_W-1:0] enable_base;
  logic [ADDR_W-1:0] priority_base;
  logic [ADDR_W-1:0] flag_base;
  logic [SRC_W-1:0]  peripheral_sources;
  logic [SRC_W-1:0]  read_only_flags;

  pic_state_t  state;
  pic_state_t  state_next;
  pic_item_t   stage;
  logic        stage_valid;
  pic_result_t out;
  pic_result_t out_next;
  logic        out_valid;
  logic        advance;
  logic        fire;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  pic_tick_t   tick;
  pic_lane_t   lane_en;
  pic_lane_t   lane_pr;
  pic_lane_t   lane_fl;
  logic [SRC_W-1:0] wmask_en;
  logic [SRC_W-1:0] wmask_pr;
  logic [SRC_W-1:0] wmask_fl;
  logic [SRC_W-1:0] wdata16;
  logic [DATA_W-1:0] rd;
  logic [DATA_W-1:0] claim;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      intcon_address     <= '0;
      rcon_address       <= '0;
      enable_base        <= '0;
      priority_base      <= '0;
      flag_base          <= '0;
      peripheral_sources <= '0;
      read_only_flags    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_INTCON:   intcon_address     <= pwdata[ADDR_W-1:0];
        REG_RCON:     rcon_address       <= pwdata[ADDR_W-1:0];
        REG_ENABLE:   enable_base        <= pwdata[ADDR_W-1:0];
        REG_PRIORITY: priority_base      <= pwdata[ADDR_W-1:0];
        REG_FLAG:     flag_base          <= pwdata[ADDR_W-1:0];
        REG_PERIPH:   peripheral_sources <= pwdata[SRC_W-1:0];
        REG_RDONLY:   read_only_flags    <= pwdata[SRC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_INTCON:   prdata = 32'(intcon_address);
      REG_RCON:     prdata = 32'(rcon_address);
      REG_ENABLE:   prdata = 32'(enable_base);
      REG_PRIORITY: prdata = 32'(priority_base);
      REG_FLAG:     prdata = 32'(flag_base);
      REG_PERIPH:   prdata = 32'(peripheral_sources);
      REG_RDONLY:   prdata = 32'(read_only_flags);
      default:      prdata = '0;
    endcase
  end

  assign advance    = !out_valid || result.ready;
  assign fire       = stage_valid && advance;
  assign item.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item.ready) begin
      stage_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      stage.operation    <= item.operation;
      stage.address      <= item.address;
      stage.write_data   <= item.write_data;
      stage.source_index <= item.source_index;
      stage.flag_value   <= item.flag_value;
    end
  end

  pic_arbiter u_arbiter (
    .state      (state),
    .peripheral (peripheral_sources),
    .tick       (tick)
  );

  assign lane_en  = pic_lane(enable_base, stage.address);
  assign lane_pr  = pic_lane(priority_base, stage.address);
  assign lane_fl  = pic_lane(flag_base, stage.address);
  assign wmask_en = lane_en.upper ? {lane_en.mask, 8'h00} : {8'h00, lane_en.mask};
  assign wmask_pr = lane_pr.upper ? {lane_pr.mask, 8'h00} : {8'h00, lane_pr.mask};
  assign wmask_fl = (lane_fl.upper ? {lane_fl.mask, 8'h00} : {8'h00, lane_fl.mask}) &
                    ~read_only_flags;
  assign wdata16  = {stage.write_data, stage.write_data};

  // Register bytes as seen before a write; overlapping vector maps OR together, INTCON wins over RCON.
  always_comb begin
    rd    = '0;
    claim = '0;
    if (stage.address == intcon_address) begin
      rd[HIGH_ENABLE_BIT] = state.enable_high;
      rd[LOW_ENABLE_BIT]  = state.enable_low;
      claim               = INTCON_MASK;
    end else if (stage.address == rcon_address) begin
      rd[PRIO_MODE_BIT] = state.prio_mode;
      claim             = RCON_MASK;
    end
    rd    = rd | (lane_en.mask & (lane_en.upper ? state.enabled[15:8] : state.enabled[7:0]))
               | (lane_pr.mask & (lane_pr.upper ? state.high[15:8] : state.high[7:0]))
               | (lane_fl.mask & (lane_fl.upper ? state.flagged[15:8] : state.flagged[7:0]));
    claim = claim | lane_en.mask | lane_pr.mask | lane_fl.mask;
  end

  always_comb begin
    state_next = state;
    out_next   = '0;
    unique case (stage.operation)
      OP_TICK: begin
        out_next.wake         = tick.wake;
        out_next.vector_taken = tick.vector_taken;
        out_next.vector_high  = tick.vector_high;
        if (tick.clear_high) begin
          state_next.enable_high = 1'b0;
        end
        if (tick.clear_low) begin
          state_next.enable_low = 1'b0;
        end
      end
      OP_READ: begin
        out_next.read_data    = rd;
        out_next.claimed_mask = claim;
      end
      OP_WRITE: begin
        out_next.claimed_mask = claim;
        if (stage.address == intcon_address) begin
          state_next.enable_high = stage.write_data[HIGH_ENABLE_BIT];
          state_next.enable_low  = stage.write_data[LOW_ENABLE_BIT];
        end else if (stage.address == rcon_address) begin
          state_next.prio_mode = stage.write_data[PRIO_MODE_BIT];
        end
        state_next.enabled = (state.enabled & ~wmask_en) | (wdata16 & wmask_en);
        state_next.high    = (state.high & ~wmask_pr) | (wdata16 & wmask_pr);
        state_next.flagged = (state.flagged & ~wmask_fl) | (wdata16 & wmask_fl);
      end
      OP_FLAG: begin
        if ({1'b0, stage.source_index} < SRC_LIMIT) begin
          state_next.flagged[stage.source_index] = stage.flag_value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out <= out_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.read_data    = out.read_data;
  assign result.claimed_mask = out.claimed_mask;
  assign result.wake         = out.wake;
  assign result.vector_taken = out.vector_taken;
  assign result.vector_high  = out.vector_high;

  // A high vector always consumes the high global enable.
  assert property (@(posedge clk) disable iff (rst)
    (fire && stage.operation == OP_TICK && tick.vector_high) |=> !state.enable_high)
    else $error("high vector left enable_high set");

  // A transaction held in the input register is not dropped while the result stalls.
  assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !advance) |=> (stage_valid && $stable(stage)))
    else $error("input register lost a transaction under stall");

  // Read data only ever comes from claimed bits.
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((result.read_data & ~result.claimed_mask) == '0))
    else $error("read data outside claimed mask");

  // A taken vector implies the tick found a request.
  assert property (@(posedge clk) disable iff (rst)
    (fire && stage.operation == OP_TICK) |=> (!out.vector_taken || out.wake))
    else $error("vector taken without wake");

endmodule

`default_nettype wire
